FILE: sv/nec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nec_pkg;

	// Width of a state index on the ports and in the edge table
	localparam int STATE_W = 5;

	localparam int MAX_EDGES_DEF   = 128;
	localparam int STATE_COUNT_DEF = 32;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic KIND_MEMBER = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	typedef struct packed {
		logic [STATE_W-1:0] from_state;
		logic               is_epsilon;
		logic [STATE_W-1:0] to_state;
	} edge_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: sv/nec_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/nfa_epsilon_closure.sv
`timescale 1ns / 1ps
`default_nettype none

// Epsilon-closure engine for a small NFA. Loads (op = 0) append one transition
// to the edge table; a load into a full table is answered by one result with
// kind = 1 and last = 1. A query (op = 1) returns every member of the epsilon
// closure of query_state in depth-first preorder, one transfer per member, with
// last set on the final one. The walk keeps the current frame in registers and
// suspended frames on a small register stack, and scans the edge table through
// the single read port of its RAM, one entry per cycle while no new member is
// held up by the output; the input is stalled for the whole walk. Results leave
// through an output register, so a stalled consumer only holds the walk when a
// new member has to be passed out.

module nfa_epsilon_closure
	import nec_pkg::*;
#(
	parameter int MAX_EDGES   = MAX_EDGES_DEF,
	parameter int STATE_COUNT = STATE_COUNT_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	// input channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire                op,
	input  wire [STATE_W-1:0]  from_state,
	input  wire                is_epsilon,
	input  wire [STATE_W-1:0]  to_state,
	input  wire [STATE_W-1:0]  query_state,
	// output channel
	output logic               out_valid,
	input  wire                out_stall,
	output logic               kind,
	output logic [STATE_W-1:0] member_state,
	output logic               last
);

	// Address and count widths of the edge table
	localparam int AW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	// Only 5-bit states exist, so at most 32 states can ever be visited
	localparam int VIS_W  = (STATE_COUNT < 32) ? STATE_COUNT : 32;
	localparam int VIS_IW = $clog2(VIS_W);
	// Suspended frames: never more than the number of visitable states
	localparam int SD  = VIS_W;
	localparam int SIW = $clog2(SD);
	localparam int SPW = $clog2(SD + 1);

	state_t state_q, state_d;

	logic [CW-1:0]      edge_count_q;
	logic [CW-1:0]      scan_q;
	logic               chk_vld_s1;
	logic [STATE_W-1:0] cur_state_q;
	logic [STATE_W-1:0] pending_q;
	logic [VIS_W-1:0]   visited_q;
	logic [SPW-1:0]     sp_q;

	logic [STATE_W-1:0] stk_state_q [SD];
	logic [CW-1:0]      stk_next_q  [SD];

	logic               kind_q;
	logic [STATE_W-1:0] member_q;
	logic               last_q;

	edge_t wr_edge;
	edge_t rd_edge;

	logic in_acc;
	logic out_free;
	logic edge_full;
	logic start_in_nfa;
	logic to_in_nfa;
	logic hit;
	logic scan_more;

	// Sequencer decisions
	logic load_wr;
	logic rej_emit;
	logic q_start;
	logic take_hit;
	logic hold;
	logic issue;
	logic pop;
	logic emit_last;

	logic [SIW-1:0]    push_idx;
	logic [SIW-1:0]    pop_idx;
	logic [SPW-1:0]    sp_m1;
	logic [VIS_IW-1:0] to_idx;
	logic [VIS_IW-1:0] start_idx;
	logic [VIS_IW-1:0] cur_idx;

	assign in_acc       = in_valid && !in_stall;
	assign out_free     = !out_valid || !out_stall;
	assign edge_full    = (edge_count_q == CW'(MAX_EDGES));
	assign start_in_nfa = ({2'b00, query_state} < 7'(STATE_COUNT));
	assign to_in_nfa    = ({2'b00, rd_edge.to_state} < 7'(STATE_COUNT));
	assign to_idx       = rd_edge.to_state[VIS_IW-1:0];
	assign start_idx    = query_state[VIS_IW-1:0];
	assign cur_idx      = cur_state_q[VIS_IW-1:0];
	assign scan_more    = (scan_q < edge_count_q);
	assign sp_m1        = sp_q - SPW'(1);
	assign push_idx     = sp_q[SIW-1:0];
	assign pop_idx      = sp_m1[SIW-1:0];

	// A table entry held in the RAM read register leads to a new member: epsilon move out of
	// the current state into a state of the NFA not yet seen in this query.
	assign hit = chk_vld_s1 && rd_edge.is_epsilon
		&& (rd_edge.from_state == cur_state_q)
		&& to_in_nfa && !visited_q[to_idx];

	assign wr_edge.from_state = from_state;
	assign wr_edge.is_epsilon = is_epsilon;
	assign wr_edge.to_state   = to_state;

	nec_ram #(
		.WIDTH ($bits(edge_t)),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (edge_count_q[AW-1:0]),
		.wr_data (wr_edge),
		.rd_en   (issue),
		.rd_addr (scan_q[AW-1:0]),
		.rd_data (rd_edge)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer decisions
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		load_wr   = 1'b0;
		rej_emit  = 1'b0;
		q_start   = 1'b0;
		take_hit  = 1'b0;
		hold      = 1'b0;
		issue     = 1'b0;
		pop       = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// A load into a full table needs the output register
				in_stall = edge_full && !out_free;
				if (in_acc) begin
					if (op == OP_LOAD) begin
						if (edge_full) begin
							rej_emit = 1'b1;
						end else begin
							load_wr = 1'b1;
						end
					end else begin
						q_start = 1'b1;
						state_d = start_in_nfa ? ST_SCAN : ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					// Pass the previous member out before taking the new one
					if (out_free) begin
						take_hit = 1'b1;
					end else begin
						hold = 1'b1;
					end
				end else if (scan_more) begin
					issue = 1'b1;
				end else if (!chk_vld_s1) begin
					// Current frame exhausted: backtrack or finish
					if (sp_q == '0) begin
						state_d = ST_DONE;
					end else begin
						pop = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers of the walk and the table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			chk_vld_s1   <= 1'b0;
			visited_q    <= '0;
			sp_q         <= '0;
			scan_q       <= '0;
			cur_state_q  <= '0;
			pending_q    <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (load_wr) begin
				edge_count_q <= edge_count_q + CW'(1);
			end

			if (!hold) begin
				chk_vld_s1 <= issue;
			end

			if (q_start) begin
				// Clear the map and mark the start state, if it is part of the NFA
				visited_q   <= start_in_nfa ? (VIS_W'(1) << start_idx) : '0;
				sp_q        <= '0;
				scan_q      <= '0;
				cur_state_q <= query_state;
				pending_q   <= query_state;
			end else if (take_hit) begin
				// Suspend the current frame and descend into the new member
				visited_q[to_idx] <= 1'b1;
				sp_q              <= sp_q + SPW'(1);
				scan_q            <= '0;
				cur_state_q       <= rd_edge.to_state;
				pending_q         <= rd_edge.to_state;
			end else if (pop) begin
				sp_q        <= sp_m1;
				scan_q      <= stk_next_q[pop_idx];
				cur_state_q <= stk_state_q[pop_idx];
			end else if (issue) begin
				scan_q <= scan_q + CW'(1);
			end

			if (rej_emit || take_hit || emit_last) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Frame stack and output payload
	always_ff @(posedge clk) begin
		if (take_hit) begin
			// scan_q already points one past the matching entry
			stk_state_q[push_idx] <= cur_state_q;
			stk_next_q[push_idx]  <= scan_q;
		end

		if (rej_emit) begin
			kind_q   <= KIND_REJECT;
			member_q <= '0;
			last_q   <= 1'b1;
		end else if (take_hit) begin
			kind_q   <= KIND_MEMBER;
			member_q <= pending_q;
			last_q   <= 1'b0;
		end else if (emit_last) begin
			kind_q   <= KIND_MEMBER;
			member_q <= pending_q;
			last_q   <= 1'b1;
		end
	end

	assign kind         = kind_q;
	assign member_state = member_q;
	assign last         = last_q;

	// No table read is left in flight once the walk has returned to idle
	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !chk_vld_s1)
		else $error("table read still in flight in idle");

	// The frame being scanned always belongs to a visited state
	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> visited_q[cur_idx])
		else $error("current frame state not marked visited");

	// The suspended-frame stack never overflows
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q < SPW'(SD))
		else $error("frame stack overflow");

	// The fill count never runs past the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= CW'(MAX_EDGES))
		else $error("edge count beyond table size");

	// A reject answers a load on its own: it is always the final result
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_REJECT |-> last && member_state == '0)
		else $error("reject result not marked last");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import nec_pkg::*;

	// One expected or observed output transfer
	typedef struct packed {
		logic               kind;
		logic [STATE_W-1:0] member;
		logic               last;
	} member_rec_t;

	// Scoreboard: mirrors the edge table, predicts the closure of every
	// accepted query in depth-first preorder and checks the output stream.
	class closure_checker;
		edge_t       edge_store [MAX_EDGES_DEF];
		int          edge_count;
		member_rec_t expected_members [$];
		int          mismatches;
		int          loads;
		int          refusals;
		int          queries;
		int          checked;
		int          widest;

		function new();
			edge_count = 0;
			mismatches = 0;
			loads      = 0;
			refusals   = 0;
			queries    = 0;
			checked    = 0;
			widest     = 0;
		endfunction

		// Walk epsilon edges from start with an explicit stack of
		// (state, next entry) frames; a state is emitted when first reached.
		function void walk_closure(logic [STATE_W-1:0] start);
			logic [STATE_COUNT_DEF-1:0] seen;
			logic [STATE_W-1:0]         frame_state [STATE_COUNT_DEF];
			int                         frame_next [STATE_COUNT_DEF];
			logic [STATE_W-1:0]         order [STATE_COUNT_DEF];
			logic [STATE_W-1:0]         target;
			int                         depth;
			int                         found;
			int                         j;
			bit                         pushed;
			member_rec_t                rec;
			seen           = '0;
			seen[start]    = 1'b1;
			order[0]       = start;
			found          = 1;
			frame_state[0] = start;
			frame_next[0]  = 0;
			depth          = 1;
			while (depth > 0) begin
				pushed = 1'b0;
				for (j = frame_next[depth-1]; j < edge_count && !pushed; j++) begin
					target = edge_store[j].to_state;
					if (edge_store[j].is_epsilon &&
					    edge_store[j].from_state == frame_state[depth-1] &&
					    !seen[target]) begin
						frame_next[depth-1] = j + 1;
						seen[target]        = 1'b1;
						order[found]        = target;
						found++;
						if (depth < STATE_COUNT_DEF) begin
							frame_state[depth] = target;
							frame_next[depth]  = 0;
							depth++;
						end
						pushed = 1'b1;
					end
				end
				if (!pushed)
					depth--;
			end
			for (j = 0; j < found; j++) begin
				rec.kind   = KIND_MEMBER;
				rec.member = order[j];
				rec.last   = (j == found - 1);
				expected_members.push_back(rec);
			end
			if (found > widest)
				widest = found;
		endfunction

		function void note_item(logic op_i, logic [STATE_W-1:0] from_i,
		                        logic eps_i, logic [STATE_W-1:0] to_i,
		                        logic [STATE_W-1:0] query_i);
			member_rec_t rec;
			if (op_i == OP_LOAD) begin
				loads++;
				if (edge_count >= MAX_EDGES_DEF) begin
					refusals++;
					rec.kind   = KIND_REJECT;
					rec.member = '0;
					rec.last   = 1'b1;
					expected_members.push_back(rec);
				end else begin
					edge_store[edge_count].from_state = from_i;
					edge_store[edge_count].is_epsilon = eps_i;
					edge_store[edge_count].to_state   = to_i;
					edge_count++;
				end
			end else begin
				queries++;
				walk_closure(query_i);
			end
		endfunction

		function void check_member(logic kind_i, logic [STATE_W-1:0] member_i,
		                           logic last_i);
			member_rec_t want;
			if (expected_members.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d state %0d last %0d",
					         kind_i, member_i, last_i);
			end else begin
				want = expected_members.pop_front();
				checked++;
				if (want.kind !== kind_i || want.member !== member_i ||
				    want.last !== last_i) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected kind %0d state %0d last %0d,",
						          " got kind %0d state %0d last %0d"},
						         want.kind, want.member, want.last,
						         kind_i, member_i, last_i);
				end
			end
		endfunction
	endclass

	localparam int HOLD_CYCLES  = 400;
	localparam int ITEMS_PER_PHASE = 31;
	localparam int DRAIN_CYCLES = 100;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               op          = OP_LOAD;
	logic [STATE_W-1:0] from_state  = '0;
	logic               is_epsilon  = 1'b0;
	logic [STATE_W-1:0] to_state    = '0;
	logic [STATE_W-1:0] query_state = '0;
	logic               out_stall   = 1'b0;
	wire                in_stall;
	wire                out_valid;
	wire                kind;
	wire [STATE_W-1:0]  member_state;
	wire                last;

	closure_checker sb;

	// Idle rates in percent, changed per phase by the stimulus process
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	// Set to request one long receiver hold-off on the next accepted query
	bit hold_armed   = 1'b0;
	int holds_done   = 0;
	int hold_count;

	nfa_epsilon_closure dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.from_state   (from_state),
		.is_epsilon   (is_epsilon),
		.to_state     (to_state),
		.query_state  (query_state),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.member_state (member_state),
		.last         (last)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: give up long after the slowest legal run would have ended
	initial begin
		#25_000_000;
		$display("timeout waiting for the closure engine");
		$display("[nfa_epsilon_closure] ERROR");
		$finish;
	end

	// Record every input transfer; values sampled here are the ones the
	// block saw at this edge, since all drivers update through NBAs.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_item(op, from_state, is_epsilon, to_state, query_state);
	end

	// Check every output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_member(kind, member_state, last);
	end

	// Receiver: stall at the phase rate. When armed, hold off for a long
	// stretch right after a query goes in, so the walk backs up into the
	// output register and the input channel stalls with an item pending.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed && in_valid && !in_stall && op == OP_QUERY) begin
				hold_armed = 1'b0;
				out_stall <= 1'b1;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
				holds_done++;
			end
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Offer one item, idling first at the phase rate; return at the edge
	// where the transfer happens.
	task automatic send_item(logic op_i, logic [STATE_W-1:0] from_i, logic eps_i,
	                         logic [STATE_W-1:0] to_i, logic [STATE_W-1:0] query_i);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= op_i;
		from_state  <= from_i;
		is_epsilon  <= eps_i;
		to_state    <= to_i;
		query_state <= query_i;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Mostly loads while the table has room, so closures grow deep; once it
	// is full, or while a hold-off waits for its query, mostly queries with
	// some loads that a full table must refuse.
	task automatic random_item();
		bit is_load;
		if (sb.edge_count < MAX_EDGES_DEF && !hold_armed)
			is_load = ($urandom_range(9) != 0);
		else
			is_load = ($urandom_range(9) < 3);
		send_item(is_load ? OP_LOAD : OP_QUERY, STATE_W'($urandom_range(31)),
		          ($urandom_range(3) != 0), STATE_W'($urandom_range(31)),
		          STATE_W'($urandom_range(31)));
	endtask

	initial begin
		int phase;
		int n;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		// Query an empty table at both ends of the state range.
		send_item(OP_QUERY, 5'd0, 1'b0, 5'd0, 5'd0);
		send_item(OP_QUERY, 5'd0, 1'b0, 5'd0, 5'd31);
		// Build a small graph: chain 0->1->2, a cycle back to 0, a non-epsilon
		// edge, a self loop, edges at the extreme states, a second branch from 0
		// and an edge into an already visited state.
		send_item(OP_LOAD, 5'd0, 1'b1, 5'd1, 5'd0);
		send_item(OP_LOAD, 5'd1, 1'b1, 5'd2, 5'd0);
		send_item(OP_LOAD, 5'd2, 1'b1, 5'd0, 5'd0);
		send_item(OP_LOAD, 5'd0, 1'b0, 5'd5, 5'd0);
		send_item(OP_LOAD, 5'd1, 1'b1, 5'd1, 5'd0);
		send_item(OP_LOAD, 5'd31, 1'b1, 5'd0, 5'd0);
		send_item(OP_LOAD, 5'd2, 1'b1, 5'd31, 5'd0);
		send_item(OP_LOAD, 5'd0, 1'b1, 5'd3, 5'd0);
		send_item(OP_LOAD, 5'd3, 1'b1, 5'd2, 5'd0);
		// Preorder with backtracking: expect 0, 1, 2, 31, 3
		send_item(OP_QUERY, 5'd0, 1'b0, 5'd0, 5'd0);
		send_item(OP_QUERY, 5'd0, 1'b0, 5'd0, 5'd31);
		// Reached only by a non-epsilon edge: closure is the state alone
		send_item(OP_QUERY, 5'd0, 1'b0, 5'd0, 5'd5);
		send_item(OP_QUERY, 5'd0, 1'b0, 5'd0, 5'd3);
		// Unused fields set to ones: query state on a load, load fields on a query
		send_item(OP_LOAD, 5'd31, 1'b1, 5'd31, 5'd31);
		send_item(OP_QUERY, 5'd31, 1'b1, 5'd31, 5'd4);
		send_item(OP_QUERY, 5'd31, 1'b1, 5'd31, 5'd31);

		// Random part: sender idle, receiver stalling, both, then neither
		// with the long receiver hold-off armed.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
				2: begin tx_idle_pct = 28; rx_stall_pct = 28; end
				default: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
					hold_armed   = 1'b1;
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				random_item();
		end
		in_valid <= 1'b0;

		// Drain, then give stray results time to show up
		while (sb.expected_members.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d loads (%0d refused on a full table), %0d closure queries,",
		         sb.loads, sb.refusals, sb.queries);
		$display("run: %0d results checked, largest closure %0d states, %0d long hold-offs",
		         sb.checked, sb.widest, holds_done);
		if (sb.mismatches == 0 && sb.expected_members.size() == 0) begin
			$display("[nfa_epsilon_closure] OK");
		end else begin
			$display("%0d mismatches, %0d results never seen", sb.mismatches,
			         sb.expected_members.size());
			$display("[nfa_epsilon_closure] ERROR");
		end
		$finish;
	end

endmodule
